FILE: src/fmpc_pkg.sv
// Shared types and constants of the first-match packet rule classifier.
// Depends on nothing; every other file of the block refers to it by scoped names.
`default_nettype none

package fmpc_pkg;

   // Default table depth in rules
   localparam int MAX_RULES_DEF = 32;

   // Request codes carried on req_type
   typedef enum logic [1:0] {
      REQ_CLASSIFY = 2'd0,
      REQ_STAGE    = 2'd1,
      REQ_APPEND   = 2'd2,
      REQ_CLEAR    = 2'd3
   } req_code_type;

   // Packet kinds, also the rule type code in word 3
   typedef enum logic [1:0] {
      KIND_IP   = 2'd0,
      KIND_TCP  = 2'd1,
      KIND_UDP  = 2'd2,
      KIND_ICMP = 2'd3
   } kind_type;

   // Sequencer states
   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_SCAN = 1'b1
   } state_type;

   // Packet header fields latched for one classify transaction
   typedef struct packed {
      logic [1:0]  kind;
      logic        direction;
      logic [7:0]  iface;
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
      logic [7:0]  proto;
      logic [15:0] field_a;
      logic [15:0] field_b;
      logic [7:0]  tcp_flags;
   } packet_type;

   // One rule: four 64-bit words, one memory row
   typedef struct packed {
      logic [63:0] w3;
      logic [63:0] w2;
      logic [63:0] w1;
      logic [63:0] w0;
   } rule_row_type;

   // Outcome of comparing one rule against the packet
   typedef struct packed {
      logic hit;
      logic deny;
      logic log;
   } hit_type;

endpackage

`default_nettype wire

FILE: src/first_match_packet_rule_classifier_unit.sv
// Top level of the first-match packet rule classifier: sequencer, staged rule words,
// rule count and result registers. Depends on fmpc_pkg, fmpc_rule_mem, fmpc_match_unit.
//
//   channel  | handshake           | payload
//   ---------+---------------------+-----------------------------------------------
//   request  | start in, busy out  | req_type, req_word_select, req_word_data, packet
//   response | rsp_valid out       | rsp_verdict, rsp_matched, rsp_match_index,
//            |                     | rsp_log_request, rsp_status
//
// A classify transaction holds busy while the memory read port hands one rule row per
// cycle to the single compare unit, until row k is the first hit or every row below
// rule_count has missed; on an empty table it reads no row, so at most MAX_RULES rows.
// The result strobes in the same cycle as busy falls.
// Stage, append and clear transactions never raise busy; their result strobes next cycle.
// Synchronous reset empties the table and zeroes the staged words; rule rows are not
// cleared, as rows at or above the count are never read.
// Each result shows for one cycle on rsp_valid; the receiver cannot stall it.
`default_nettype none

module first_match_packet_rule_classifier_unit #(
   parameter int MAX_RULES = fmpc_pkg::MAX_RULES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_type,
   input  wire logic [1:0]  req_word_select,
   input  wire logic [63:0] req_word_data,
   input  wire logic [1:0]  req_packet_kind,
   input  wire logic        req_direction,
   input  wire logic [7:0]  req_iface,
   input  wire logic [31:0] req_src_ip,
   input  wire logic [31:0] req_dst_ip,
   input  wire logic [7:0]  req_proto,
   input  wire logic [15:0] req_l4_field_a,
   input  wire logic [15:0] req_l4_field_b,
   input  wire logic [7:0]  req_tcp_flags,
   output logic             rsp_valid,
   output logic             rsp_verdict,
   output logic             rsp_matched,
   output logic [4:0]       rsp_match_index,
   output logic             rsp_log_request,
   output logic             rsp_status
);

   localparam int CNT_W = $clog2(MAX_RULES + 1);
   localparam int IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;

   fmpc_pkg::state_type  state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     fetch_ff, fetch_in;
   logic                 chk_pend_ff, chk_pend_in;
   logic [IDX_W-1:0]     chk_idx_ff, chk_idx_in;
   fmpc_pkg::packet_type pkt_ff, pkt_in;
   logic [63:0]          staged_ff [4];
   logic [63:0]          staged_in [4];

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_verdict_ff, rsp_verdict_in;
   logic                 rsp_matched_ff, rsp_matched_in;
   logic [IDX_W-1:0]     rsp_index_ff, rsp_index_in;
   logic                 rsp_log_ff, rsp_log_in;
   logic                 rsp_status_ff, rsp_status_in;

   logic                   accept;
   logic                   table_full;
   logic                   scan_done;
   logic                   mem_wr_en;
   logic                   mem_rd_en;
   logic [IDX_W-1:0]       mem_rd_addr;
   fmpc_pkg::rule_row_type staged_rule;
   fmpc_pkg::rule_row_type rd_rule;
   fmpc_pkg::hit_type      cmp;

   assign busy       = (state_ff != fmpc_pkg::ST_IDLE);
   assign accept     = start && !busy;
   assign table_full = (count_ff >= CNT_W'(MAX_RULES));
   assign scan_done  = !chk_pend_ff && (fetch_ff >= count_ff);

   assign staged_rule = '{w3: staged_ff[3], w2: staged_ff[2],
                          w1: staged_ff[1], w0: staged_ff[0]};

   // Rule table
   fmpc_rule_mem #(
      .DEPTH  (MAX_RULES),
      .ADDR_W (IDX_W)
   ) u_rule_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (staged_rule),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (rd_rule)
   );

   // Shared compare unit, fed by the registered row
   fmpc_match_unit u_match (
      .pkt    (pkt_ff),
      .rule   (rd_rule),
      .result (cmp)
   );

   // Sequencer: next state, table updates and result values
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      fetch_in       = fetch_ff;
      chk_pend_in    = 1'b0;
      chk_idx_in     = chk_idx_ff;
      pkt_in         = pkt_ff;
      staged_in      = staged_ff;
      rsp_valid_in   = 1'b0;
      rsp_verdict_in = 1'b0;
      rsp_matched_in = 1'b0;
      rsp_index_in   = '0;
      rsp_log_in     = 1'b0;
      rsp_status_in  = 1'b0;
      mem_wr_en      = 1'b0;
      mem_rd_en      = 1'b0;
      mem_rd_addr    = fetch_ff[IDX_W-1:0];

      unique case (state_ff)
         fmpc_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_type)
                  fmpc_pkg::REQ_CLASSIFY: begin
                     // Latch the packet and start the scan at rule zero
                     pkt_in = '{kind: req_packet_kind, direction: req_direction,
                                iface: req_iface, src_ip: req_src_ip,
                                dst_ip: req_dst_ip, proto: req_proto,
                                field_a: req_l4_field_a, field_b: req_l4_field_b,
                                tcp_flags: req_tcp_flags};
                     fetch_in = '0;
                     state_in = fmpc_pkg::ST_SCAN;
                  end
                  fmpc_pkg::REQ_STAGE: begin
                     staged_in[req_word_select] = req_word_data;
                     rsp_valid_in = 1'b1;
                  end
                  fmpc_pkg::REQ_APPEND: begin
                     // Refuse when full, else copy the staged words into the next row
                     if (table_full) begin
                        rsp_status_in = 1'b1;
                     end else begin
                        mem_wr_en = 1'b1;
                        count_in  = count_ff + CNT_W'(1);
                     end
                     rsp_valid_in = 1'b1;
                  end
                  default: begin
                     count_in     = '0;
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         default: begin
            // Issue the next row while rows remain
            if (fetch_ff < count_ff) begin
               mem_rd_en   = 1'b1;
               fetch_in    = fetch_ff + CNT_W'(1);
               chk_pend_in = 1'b1;
               chk_idx_in  = fetch_ff[IDX_W-1:0];
            end
            // Finish on the first hit, or when every row missed
            if (chk_pend_ff && cmp.hit) begin
               rsp_valid_in   = 1'b1;
               rsp_verdict_in = cmp.deny;
               rsp_matched_in = 1'b1;
               rsp_index_in   = chk_idx_ff;
               rsp_log_in     = cmp.log;
               mem_rd_en      = 1'b0;
               chk_pend_in    = 1'b0;
               state_in       = fmpc_pkg::ST_IDLE;
            end else if (scan_done) begin
               rsp_valid_in = 1'b1;
               state_in     = fmpc_pkg::ST_IDLE;
            end
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fmpc_pkg::ST_IDLE;
         count_ff     <= '0;
         fetch_ff     <= '0;
         chk_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         staged_ff    <= '{default: '0};
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         fetch_ff     <= fetch_in;
         chk_pend_ff  <= chk_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         staged_ff    <= staged_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      chk_idx_ff     <= chk_idx_in;
      pkt_ff         <= pkt_in;
      rsp_verdict_ff <= rsp_verdict_in;
      rsp_matched_ff <= rsp_matched_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_log_ff     <= rsp_log_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_verdict     = rsp_verdict_ff;
   assign rsp_matched     = rsp_matched_ff;
   assign rsp_match_index = 5'(rsp_index_ff);
   assign rsp_log_request = rsp_log_ff;
   assign rsp_status      = rsp_status_ff;

   // Table never grows past its depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_RULES))
      else $error("rule count exceeds table depth");

   // A scan with nothing left to check ends with a transaction next cycle
   a_scan_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fmpc_pkg::ST_SCAN) && scan_done |=>
         rsp_valid_ff && (state_ff == fmpc_pkg::ST_IDLE))
      else $error("scan did not finish");

   // Table maintenance requests answer in the next cycle
   a_quick_answer: assert property (@(posedge clock) disable iff (reset)
      accept && (req_type != fmpc_pkg::REQ_CLASSIFY) |=> rsp_valid_ff)
      else $error("maintenance request not answered");

   // A refused append never carries a match
   a_status_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff |-> !rsp_matched_ff && !rsp_verdict_ff)
      else $error("status and match both set");

   // Memory reads stay below the rule count
   a_read_range: assert property (@(posedge clock) disable iff (reset)
      mem_rd_en |-> (fetch_ff < count_ff))
      else $error("read beyond rule count");

endmodule

`default_nettype wire

FILE: src/fmpc_rule_mem.sv
// Rule table memory: one rule per row, one write and one registered read per cycle.
// Depends on fmpc_pkg for the rule row type.
`default_nettype none

module fmpc_rule_mem #(
   parameter int DEPTH  = fmpc_pkg::MAX_RULES_DEF,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                   clock,
   input  wire logic                   wr_en,
   input  wire logic [ADDR_W-1:0]      wr_addr,
   input  wire fmpc_pkg::rule_row_type wr_data,
   input  wire logic                   rd_en,
   input  wire logic [ADDR_W-1:0]      rd_addr,
   output fmpc_pkg::rule_row_type      rd_data
);

   fmpc_pkg::rule_row_type mem_ff [DEPTH];

   // Write the appended rule
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Register the scanned row
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: src/fmpc_match_unit.sv
// Shared rule compare unit: checks one rule row against the latched packet.
// Depends on fmpc_pkg for packet, rule and outcome types and the kind codes.
`default_nettype none

module fmpc_match_unit (
   input  wire fmpc_pkg::packet_type   pkt,
   input  wire fmpc_pkg::rule_row_type rule,
   output fmpc_pkg::hit_type           result
);

   // Port check: lo zero is any, hi zero is exact, else an inclusive range
   function automatic logic port_ok(input logic [15:0] lo, input logic [15:0] hi,
                                    input logic [15:0] port);
      logic ok;
      if (lo == 16'd0) begin
         ok = 1'b1;
      end else if (hi == 16'd0) begin
         ok = (port == lo);
      end else begin
         ok = (port >= lo) && (port <= hi);
      end
      return ok;
   endfunction

   logic        kind_ok;
   logic        dir_ok;
   logic        iface_ok;
   logic        src_ok;
   logic        dst_ok;
   logic        ports_ok;
   logic        flags_ok;
   logic        l4_ok;
   logic [31:0] smask;
   logic [31:0] dmask;
   logic [7:0]  riface;
   logic [7:0]  fset;
   logic [7:0]  funset;

   // Evaluate every condition of the rule in parallel
   always_comb begin
      smask  = rule.w0[63:32];
      dmask  = rule.w1[63:32];
      riface = rule.w3[15:8];
      fset   = rule.w3[23:16];
      funset = rule.w3[31:24];

      kind_ok  = (rule.w3[1:0] == pkt.kind);
      dir_ok   = (rule.w3[2] == pkt.direction);
      iface_ok = (riface == 8'd0) || (riface == pkt.iface);
      src_ok   = ((rule.w0[31:0] & smask) == (pkt.src_ip & smask));
      dst_ok   = ((rule.w1[31:0] & dmask) == (pkt.dst_ip & dmask));
      ports_ok = port_ok(rule.w2[15:0], rule.w2[31:16], pkt.field_a) &&
                 port_ok(rule.w2[47:32], rule.w2[63:48], pkt.field_b);
      flags_ok = ((fset == 8'd0) || ((pkt.tcp_flags & fset) != 8'd0)) &&
                 ((funset == 8'd0) || ((pkt.tcp_flags & funset) == 8'd0));

      // Kind-specific layer 4 checks
      unique case (pkt.kind)
         fmpc_pkg::KIND_IP: begin
            l4_ok = !rule.w3[5] || (rule.w2[7:0] == pkt.proto);
         end
         fmpc_pkg::KIND_ICMP: begin
            l4_ok = (!rule.w3[6] || (rule.w2[7:0] == pkt.field_a[7:0])) &&
                    (!rule.w3[7] || (rule.w2[15:8] == pkt.field_b[7:0]));
         end
         fmpc_pkg::KIND_TCP: begin
            l4_ok = ports_ok && flags_ok;
         end
         default: begin
            l4_ok = ports_ok;
         end
      endcase

      result.hit  = kind_ok && dir_ok && iface_ok && src_ok && dst_ok && l4_ok;
      result.deny = rule.w3[3];
      result.log  = rule.w3[4];
   end

endmodule

`default_nettype wire
